// ===== rtl/core/vbs_pkg.sv =====
package vbs_pkg;

	// Format selector codes.
	typedef enum logic [2:0] {
		OP_BYTE   = 3'd0,
		OP_LE16   = 3'd1,
		OP_LE32   = 3'd2,
		OP_LE64   = 3'd3,
		OP_VARINT = 3'd4
	} op_t;

	localparam int unsigned VALUE_W    = 64;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned GROUP_BITS = 7;
	localparam int unsigned MAX_BYTES  = 10;
	localparam int unsigned COUNT_W    = $clog2(MAX_BYTES + 1);
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);

	// One classified item as it travels from the front to the back.
	typedef struct packed {
		logic                 varint;
		logic [COUNT_W-1:0]   count;
		logic [VALUE_W-1:0]   value;
	} entry_t;

	// Number of bytes of an unsigned LEB128 varint: one more than the index of
	// the highest non-zero seven-bit group, and at least one.
	function automatic logic [COUNT_W-1:0] varint_count(input logic [VALUE_W-1:0] v);
		logic [COUNT_W-1:0] cnt;
		cnt = COUNT_W'(1);
		for (int i = 1; i < MAX_BYTES; i++) begin
			if ((v >> (GROUP_BITS * i)) != '0) begin
				cnt = COUNT_W'(i + 1);
			end
		end
		return cnt;
	endfunction

endpackage

// ===== rtl/core/vbs_front.sv =====
module vbs_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        operation,
	input  logic [vbs_pkg::VALUE_W-1:0]       value,
	output logic                              push_valid,
	output vbs_pkg::entry_t                   push_entry,
	input  logic                              push_ready
);

	logic            valid_s1;
	vbs_pkg::entry_t entry_s1;
	logic            advance;
	logic            legal;
	vbs_pkg::entry_t entry_d;

	// Classify the format into a byte count; unused codes are dropped here.
	always_comb begin
		legal          = 1'b1;
		entry_d.value  = value;
		entry_d.varint = 1'b0;
		entry_d.count  = vbs_pkg::COUNT_W'(1);
		case (operation)
			vbs_pkg::OP_BYTE: begin
				entry_d.count = vbs_pkg::COUNT_W'(1);
			end
			vbs_pkg::OP_LE16: begin
				entry_d.count = vbs_pkg::COUNT_W'(2);
			end
			vbs_pkg::OP_LE32: begin
				entry_d.count = vbs_pkg::COUNT_W'(4);
			end
			vbs_pkg::OP_LE64: begin
				entry_d.count = vbs_pkg::COUNT_W'(8);
			end
			vbs_pkg::OP_VARINT: begin
				entry_d.varint = 1'b1;
				entry_d.count  = vbs_pkg::varint_count(value);
			end
			default: begin
				legal = 1'b0;
			end
		endcase
	end

	assign advance    = !valid_s1 || push_ready;
	assign in_stall   = !advance;
	assign push_valid = valid_s1;
	assign push_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid && legal;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			entry_s1 <= entry_d;
		end
	end

endmodule

// ===== rtl/core/vbs_queue.sv =====
module vbs_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  vbs_pkg::entry_t push_entry,
	output logic            push_ready,
	input  logic            pop,
	output logic            pop_valid,
	output vbs_pkg::entry_t pop_entry
);

	vbs_pkg::entry_t                    slot_q [vbs_pkg::QUEUE_DEPTH];
	logic [vbs_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [vbs_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [vbs_pkg::QCNT_W-1:0]         count_q;
	logic                               do_push;
	logic                               do_pop;

	assign push_ready = count_q != vbs_pkg::QCNT_W'(vbs_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_entry  = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== rtl/core/vbs_back.sv =====
module vbs_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  vbs_pkg::entry_t              q_entry,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [vbs_pkg::BYTE_W-1:0]   out_byte,
	output logic                         last
);

	logic                          busy_q;
	logic                          varint_q;
	logic [vbs_pkg::COUNT_W-1:0]   remain_q;
	logic [vbs_pkg::VALUE_W-1:0]   shift_q;
	logic                          out_valid_q;
	logic [vbs_pkg::BYTE_W-1:0]    out_byte_q;
	logic                          last_q;
	logic                          take;
	logic                          emit;
	logic                          final_byte;
	logic                          done;
	logic [vbs_pkg::BYTE_W-1:0]    byte_d;

	assign take       = !out_valid_q || !out_stall;
	assign emit       = busy_q && take;
	assign final_byte = remain_q == vbs_pkg::COUNT_W'(1);
	assign done       = !busy_q || (emit && final_byte);
	assign q_pop      = done && q_valid;

	// A varint byte carries seven value bits and a flag that is set while
	// more bytes follow.
	assign byte_d = varint_q ? {!final_byte, shift_q[vbs_pkg::GROUP_BITS-1:0]}
	                         : shift_q[vbs_pkg::BYTE_W-1:0];

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (emit && final_byte) begin
				busy_q <= 1'b0;
			end
			if (take) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			varint_q <= q_entry.varint;
			remain_q <= q_entry.count;
			shift_q  <= q_entry.value;
		end else if (emit) begin
			remain_q <= remain_q - 1'b1;
			shift_q  <= varint_q ? (shift_q >> vbs_pkg::GROUP_BITS)
			                     : (shift_q >> vbs_pkg::BYTE_W);
		end
		if (emit) begin
			out_byte_q <= byte_d;
			last_q     <= final_byte;
		end
	end

endmodule

// ===== rtl/core/value_byte_serializer.sv =====
// Each item passes through the front register, the queue and the byte engine's output register.
// Throughput: one output byte per cycle while items are waiting and out_stall is low; an item
// yields 1, 2, 4 or 8 bytes for the packed formats and 1 to 10 for a varint.
// Items with an unused format code are accepted and produce no bytes.
// Reset (arst_n low, asynchronous) empties the front register, the queue and the output.
module value_byte_serializer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        operation,
	input  logic [vbs_pkg::VALUE_W-1:0]       value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [vbs_pkg::BYTE_W-1:0]        out_byte,
	output logic                              last
);

	// The front register classifies each beat into a format and a byte count.
	// For a varint the count is found at once from which seven-bit groups of the
	// value are non-zero, so the back never has to test the remaining value.
	logic            push_valid;
	logic            push_ready;
	vbs_pkg::entry_t push_entry;

	// A two-entry queue decouples the front from the byte engine, so that input
	// beats keep flowing while a long item is still being emitted.
	logic            q_valid;
	logic            q_pop;
	vbs_pkg::entry_t q_entry;

	vbs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.value      (value),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	vbs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_entry  (q_entry)
	);

	// The byte engine shifts the value down by eight bits (packed formats) or
	// seven bits (varint) per byte, and loads the next item in the same cycle
	// as it hands over the final byte of the current one. Its output register
	// holds a stalled byte steady while the engine waits.
	vbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule

// ===== tb/sv/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// The watchdog gives up after this many cycles in which no beat is taken on
	// either channel. The slowest legitimate waits come from runs of sender or
	// receiver idling at 87 per cent, which end long before this limit, so this
	// leaves a wide margin.
	localparam int unsigned QUIET_LIMIT = 4000;
	// Cycles to keep watching the output once nothing more is expected. The
	// first byte of an item reaches the output through the front register, the
	// queue and the byte engine, so this comfortably covers anything still in flight.
	localparam int unsigned DRAIN_CYCLES = 24;
	localparam int unsigned MAX_REPORTS = 10;

	// One expected output beat: the byte and its end-of-item mark.
	typedef struct packed {
		logic [vbs_pkg::BYTE_W-1:0] data;
		logic                       is_last;
	} byte_beat_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [2:0]                  operation = '0;
	logic [vbs_pkg::VALUE_W-1:0] value = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [vbs_pkg::BYTE_W-1:0]  out_byte;
	logic                        last;

	// Bytes that the serializer still owes, oldest first.
	byte_beat_t pending_bytes[$];
	int unsigned failures = 0;
	int unsigned quiet_cycles = 0;
	// Percentages of cycles in which the sender and the receiver hold back.
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	value_byte_serializer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Works out the byte stream that one accepted item should produce and
	// appends it to the queue of owed bytes. Packed formats give their low
	// bytes, least significant first; the varint gives seven-bit groups, low
	// group first, with the top bit set on every byte that has a successor.
	// Unused format codes give nothing at all.
	function automatic void serialize_value(input logic [2:0] op,
		input logic [vbs_pkg::VALUE_W-1:0] v);
		int unsigned                 n_bytes;
		int unsigned                 produced;
		logic [vbs_pkg::VALUE_W-1:0] rest;
		byte_beat_t                  beat;
		n_bytes = 0;
		case (op)
			vbs_pkg::OP_BYTE: n_bytes = 1;
			vbs_pkg::OP_LE16: n_bytes = 2;
			vbs_pkg::OP_LE32: n_bytes = 4;
			vbs_pkg::OP_LE64: n_bytes = 8;
			default: n_bytes = 0;
		endcase
		for (int unsigned i = 0; i < n_bytes; i++) begin
			beat.data = v[8*i +: 8];
			beat.is_last = (i + 1 == n_bytes);
			pending_bytes.insert(pending_bytes.size(), beat);
		end
		if (op == vbs_pkg::OP_VARINT) begin
			rest = v;
			produced = 0;
			do begin
				beat.data[6:0] = rest[6:0];
				rest = rest >> vbs_pkg::GROUP_BITS;
				beat.data[7] = (rest != '0);
				beat.is_last = (rest == '0);
				pending_bytes.insert(pending_bytes.size(), beat);
				produced++;
			end while (rest != '0 && produced < vbs_pkg::MAX_BYTES);
		end
	endfunction

	task automatic record_failure(input string msg);
		failures++;
		if (failures <= MAX_REPORTS) begin
			$display("%0t: %s", $realtime, msg);
		end
	endtask

	// Offers one item on the input channel, idling beforehand at the current
	// sender rate, and holds the payload steady until the beat is taken. The
	// expectation is recorded at the accepting edge, well before the first
	// byte can appear. Each call starts in the time step of a rising edge, so
	// in_valid gets exactly one assignment per step even between items.
	task automatic send_item(input logic [2:0] op, input logic [vbs_pkg::VALUE_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		value     <= v;
		do @(posedge clk); while (in_stall);
		serialize_value(op, v);
	endtask

	// The receiver stalls at random at the current rate. Stall is free to
	// change at any edge, whether or not a byte is on offer.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Every byte taken from the output is compared with the oldest one owed.
	// Values are read straight after the edge, so they are the ones that the
	// edge itself sampled.
	always @(posedge clk) begin
		byte_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bytes.size() == 0) begin
				record_failure($sformatf("unexpected byte 0x%02h last=%0b", out_byte, last));
			end else begin
				want = pending_bytes.pop_front();
				if (out_byte !== want.data || last !== want.is_last) begin
					record_failure($sformatf("byte 0x%02h last=%0b, expected 0x%02h last=%0b",
						out_byte, last, want.data, want.is_last));
				end
			end
		end
	end

	// Watchdog: a long stretch with no beat on either side means the block has
	// hung, so the run is abandoned.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
			$display("FAIL value_byte_serializer");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// A raw byte takes only the low eight bits, whatever lies above them.
	task automatic test_raw_byte();
		send_item(vbs_pkg::OP_BYTE, 64'h0);
		send_item(vbs_pkg::OP_BYTE, '1);
		send_item(vbs_pkg::OP_BYTE, 64'hFFFF_FFFF_FFFF_FF00);
	endtask

	// The packed formats at their extremes, with junk above the format's width
	// for the narrow ones so that discarding the high bits is seen.
	task automatic test_packed_le();
		send_item(vbs_pkg::OP_LE16, 64'h0);
		send_item(vbs_pkg::OP_LE16, 64'h0123_4567_89AB_CDEF);
		send_item(vbs_pkg::OP_LE16, 64'hFFFF_FFFF_FFFF_0000);
		send_item(vbs_pkg::OP_LE32, 64'h0);
		send_item(vbs_pkg::OP_LE32, '1);
		send_item(vbs_pkg::OP_LE32, 64'hDEAD_BEEF_0000_0000);
		send_item(vbs_pkg::OP_LE64, 64'h0);
		send_item(vbs_pkg::OP_LE64, '1);
		send_item(vbs_pkg::OP_LE64, 64'h0123_4567_89AB_CDEF);
		send_item(vbs_pkg::OP_LE64, 64'h8000_0000_0000_0001);
	endtask

	// Varint group boundaries: zero as a single byte, the edges of one and two
	// groups, the smallest and largest nine-byte values, and the ten-byte values
	// that need the top bit, including the all-ones pattern that would loop for
	// ever if it were shifted as a signed number.
	task automatic test_varint_groups();
		send_item(vbs_pkg::OP_VARINT, 64'h0);
		send_item(vbs_pkg::OP_VARINT, 64'h1);
		send_item(vbs_pkg::OP_VARINT, 64'h7F);
		send_item(vbs_pkg::OP_VARINT, 64'h80);
		send_item(vbs_pkg::OP_VARINT, 64'h3FFF);
		send_item(vbs_pkg::OP_VARINT, 64'h4000);
		send_item(vbs_pkg::OP_VARINT, 64'h0100_0000_0000_0000);
		send_item(vbs_pkg::OP_VARINT, 64'h7FFF_FFFF_FFFF_FFFF);
		send_item(vbs_pkg::OP_VARINT, 64'h8000_0000_0000_0000);
		send_item(vbs_pkg::OP_VARINT, '1);
	endtask

	// Unused format codes must be swallowed without a single byte. A normal
	// item follows so that any stray output would land against it.
	task automatic test_unused_codes();
		send_item(3'd5, {$urandom, $urandom});
		send_item(3'd6, {$urandom, $urandom});
		send_item(3'd7, '1);
		send_item(vbs_pkg::OP_BYTE, 64'hA5);
	endtask

	// Random items, counted only when they produce bytes. Most pick a real
	// format; a few use unused codes as noise. Varint values are cut to a
	// random bit length so that every byte count from one to ten turns up.
	task automatic test_random_traffic(input int unsigned sender_pct,
		input int unsigned receiver_pct, input int unsigned n_items);
		int unsigned                 sent;
		int unsigned                 width;
		logic [2:0]                  op;
		logic [vbs_pkg::VALUE_W-1:0] v;
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 6) begin
				op = 3'($urandom_range(7, 5));
			end else begin
				op = 3'($urandom_range(4));
			end
			v = {$urandom, $urandom};
			if (op == vbs_pkg::OP_VARINT) begin
				width = $urandom_range(64);
				v = (width == 0) ? '0 : v >> (vbs_pkg::VALUE_W - width);
			end
			send_item(op, v);
			if (op <= vbs_pkg::OP_VARINT) begin
				sent++;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// The directed part runs under the first idling pattern: a sluggish
		// receiver keeps the internal queue full for much of the time.
		send_idle_pct = 36;
		recv_idle_pct = 87;
		test_raw_byte();
		test_packed_le();
		test_varint_groups();
		test_unused_codes();

		test_random_traffic(36, 87, 90);
		test_random_traffic(87, 36, 90);
		test_random_traffic(0, 0, 90);

		// All stimulus is in; drop valid in the step of the last beat, wait for
		// the owed bytes and then watch for anything extra.
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0 && pending_bytes.size() == 0) begin
			$display("PASS value_byte_serializer");
		end else begin
			$display("FAIL value_byte_serializer");
		end
		$finish;
	end

endmodule
